[hdl/rmme_pkg.sv]
// ----------------------------------------------------------------------------
// rmme_pkg
// Shared types and codes for the register-memory machine execute block.
// ----------------------------------------------------------------------------
package rmme_pkg;

	localparam logic [7:0] OP_LOAD   = 8'h00;
	localparam logic [7:0] OP_ADD_M  = 8'h01;
	localparam logic [7:0] OP_SUB_M  = 8'h02;
	localparam logic [7:0] OP_MUL_M  = 8'h03;
	localparam logic [7:0] OP_DIV_M  = 8'h04;
	localparam logic [7:0] OP_CMP_M  = 8'h05;
	localparam logic [7:0] OP_STORE  = 8'h10;
	localparam logic [7:0] OP_AMUL_M = 8'h13;
	localparam logic [7:0] OP_ADIV_M = 8'h14;
	localparam logic [7:0] OP_MOV    = 8'h20;
	localparam logic [7:0] OP_ADD    = 8'h21;
	localparam logic [7:0] OP_SUB    = 8'h22;
	localparam logic [7:0] OP_MUL    = 8'h23;
	localparam logic [7:0] OP_DIV    = 8'h24;
	localparam logic [7:0] OP_CMP    = 8'h25;
	localparam logic [7:0] OP_AMUL   = 8'h33;
	localparam logic [7:0] OP_ADIV   = 8'h34;
	localparam logic [7:0] OP_JMP    = 8'h80;
	localparam logic [7:0] OP_JEQ    = 8'h81;
	localparam logic [7:0] OP_JNE    = 8'h82;
	localparam logic [7:0] OP_JLT    = 8'h83;
	localparam logic [7:0] OP_JGE    = 8'h84;
	localparam logic [7:0] OP_JGT    = 8'h85;
	localparam logic [7:0] OP_JLE    = 8'h86;
	localparam logic [7:0] OP_JLT_A  = 8'h93;
	localparam logic [7:0] OP_JGE_A  = 8'h94;
	localparam logic [7:0] OP_JGT_A  = 8'h95;
	localparam logic [7:0] OP_JLE_A  = 8'h96;
	localparam logic [7:0] OP_STOP   = 8'h99;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOREG = 2'd1;
	localparam logic [1:0] ST_NOMEM = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CL_NONE, CL_INIT, CL_HALT, CL_RR, CL_RM, CL_JUMP
	} cls_t;

	typedef enum logic [3:0] {
		K_NONE, K_MOV, K_LOAD, K_STORE, K_ADD, K_SUB, K_MUL, K_AMUL,
		K_DIV, K_ADIV, K_CMP
	} kind_t;

	typedef struct packed {
		cls_t        cls;
		kind_t       kind;
		logic [7:0]  opcode;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [15:0] address;
		logic [15:0] init_value;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

[hdl/register_memory_machine_execute.sv]
// ----------------------------------------------------------------------------
// register_memory_machine_execute
// Execute unit of a small register-memory machine, front/queue/back split.
// ----------------------------------------------------------------------------
// After reset the block sweeps the written marks of its data memory, one word
// a cycle, and accepts no request until done. Each request then goes through
// the back end's register read, memory read where needed, execute and result
// steps, and multiply, abs-multiply, divide and abs-divide also run through
// the shift-add/subtract unit, which retires one bit a cycle. A two-entry
// queue lets new requests be taken while the back end works, and a result
// register holds the answer until it is taken.
module register_memory_machine_execute #(
	parameter int ADDR_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        req_type,
	input  logic [7:0]  opcode,
	input  logic [3:0]  reg_a,
	input  logic [3:0]  reg_b,
	input  logic [15:0] address,
	input  logic [15:0] init_value,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic        branch_taken,
	output logic [15:0] jump_target,
	output logic        halt
);

	rmme_pkg::cmd_t       push_cmd, head;
	rmme_pkg::back_stat_t bstat;
	logic                 push, pop, q_full, q_not_empty;

	rmme_front u_front (
		.req_type   (req_type),
		.opcode     (opcode),
		.reg_a      (reg_a),
		.reg_b      (reg_b),
		.address    (address),
		.init_value (init_value),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.bstat      (bstat),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	rmme_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	rmme_back #(
		.ADDR_BITS (ADDR_BITS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.head         (head),
		.pop          (pop),
		.bstat        (bstat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.branch_taken (branch_taken),
		.jump_target  (jump_target),
		.halt         (halt)
	);

endmodule

[hdl/rmme_front.sv]
// ----------------------------------------------------------------------------
// rmme_front
// Accepts requests and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module rmme_front (
	input  logic                req_type,
	input  logic [7:0]          opcode,
	input  logic [3:0]          reg_a,
	input  logic [3:0]          reg_b,
	input  logic [15:0]         address,
	input  logic [15:0]         init_value,
	input  logic                item_valid,
	output logic                item_ready,
	input  rmme_pkg::back_stat_t bstat,
	input  logic                q_full,
	output logic                push,
	output rmme_pkg::cmd_t      cmd
);

	rmme_pkg::cls_t  cls;
	rmme_pkg::kind_t kind;

	always_comb begin
		unique case (opcode)
			rmme_pkg::OP_MOV:                      kind = rmme_pkg::K_MOV;
			rmme_pkg::OP_LOAD:                     kind = rmme_pkg::K_LOAD;
			rmme_pkg::OP_STORE:                    kind = rmme_pkg::K_STORE;
			rmme_pkg::OP_ADD, rmme_pkg::OP_ADD_M:   kind = rmme_pkg::K_ADD;
			rmme_pkg::OP_SUB, rmme_pkg::OP_SUB_M:   kind = rmme_pkg::K_SUB;
			rmme_pkg::OP_MUL, rmme_pkg::OP_MUL_M:   kind = rmme_pkg::K_MUL;
			rmme_pkg::OP_AMUL, rmme_pkg::OP_AMUL_M: kind = rmme_pkg::K_AMUL;
			rmme_pkg::OP_DIV, rmme_pkg::OP_DIV_M:   kind = rmme_pkg::K_DIV;
			rmme_pkg::OP_ADIV, rmme_pkg::OP_ADIV_M: kind = rmme_pkg::K_ADIV;
			rmme_pkg::OP_CMP, rmme_pkg::OP_CMP_M:   kind = rmme_pkg::K_CMP;
			default:                               kind = rmme_pkg::K_NONE;
		endcase
	end

	always_comb begin
		priority if (req_type) begin
			cls = rmme_pkg::CL_INIT;
		end else if (opcode == rmme_pkg::OP_STOP) begin
			cls = rmme_pkg::CL_HALT;
		end else if (opcode[7:4] == 4'h2 || opcode[7:4] == 4'h3) begin
			cls = (kind == rmme_pkg::K_NONE) ? rmme_pkg::CL_NONE : rmme_pkg::CL_RR;
		end else if (opcode[7:4] == 4'h0 || opcode[7:4] == 4'h1) begin
			cls = (kind == rmme_pkg::K_NONE) ? rmme_pkg::CL_NONE : rmme_pkg::CL_RM;
		end else if ((opcode >= rmme_pkg::OP_JMP && opcode <= rmme_pkg::OP_JLE) ||
			(opcode >= rmme_pkg::OP_JLT_A && opcode <= rmme_pkg::OP_JLE_A)) begin
			cls = rmme_pkg::CL_JUMP;
		end else begin
			cls = rmme_pkg::CL_NONE;
		end
	end

	// hold off requests while the queue is full or the memory marks are being swept
	assign item_ready = !q_full && !bstat.clearing;
	assign push       = item_valid && item_ready;

	always_comb begin
		cmd.cls        = cls;
		cmd.kind       = kind;
		cmd.opcode     = opcode;
		cmd.reg_a      = reg_a;
		cmd.reg_b      = reg_b;
		cmd.address    = address;
		cmd.init_value = init_value;
	end

endmodule

[hdl/rmme_queue.sv]
// ----------------------------------------------------------------------------
// rmme_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rmme_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rmme_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output rmme_pkg::cmd_t head
);

	localparam int PW = $clog2(rmme_pkg::QDEPTH);

	rmme_pkg::cmd_t   ent_q [rmme_pkg::QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full      = cnt_q == (PW+1)'(rmme_pkg::QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_cmd;
	end

endmodule

[hdl/rmme_back.sv]
// ----------------------------------------------------------------------------
// rmme_back
// Executes commands: register file, data memory, shift-add/subtract unit.
// ----------------------------------------------------------------------------
module rmme_back #(
	parameter int ADDR_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  rmme_pkg::cmd_t      head,
	output logic                pop,
	output rmme_pkg::back_stat_t bstat,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [1:0]          status,
	output logic                branch_taken,
	output logic [15:0]         jump_target,
	output logic                halt
);

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(WORD_BITS);
	localparam logic [15:0] IV_MASK = (ADDR_BITS >= 16) ? 16'hFFFF :
		16'((1 << ADDR_BITS) - 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_REG   = 9'b000000100,
		S_MEM   = 9'b000001000,
		S_EXEC  = 9'b000010000,
		S_ITER  = 9'b000100000,
		S_FIX   = 9'b001000000,
		S_WR2   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	state_t state_q;
	rmme_pkg::cmd_t cmd_q;
	logic [ADDR_BITS-1:0] clr_q;
	logic [15:0] wr_q;
	logic [W-1:0] cmp_l_q, cmp_r_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0] rf [16];
	logic [W-1:0] rda_q, rdb_q;
	logic [W:0]   mem [2**ADDR_BITS];
	logic [W:0]   mem_rd_q;
	logic [W-1:0] opy_q, opx_q, acc_q, sh_q;

	logic [1:0]  res_st_q;
	logic        res_tk_q, res_hl_q;
	logic [15:0] res_tg_q;
	logic        out_free;

	// combinational decisions
	logic                 rf_we;
	logic [3:0]           rf_wa;
	logic [W-1:0]         rf_wd;
	logic                 mem_we, mem_re;
	logic [ADDR_BITS-1:0] mem_wa, ea;
	logic [W:0]           mem_wd;
	logic                 wa, wb, take;
	logic [W:0]           trial;
	logic [W-1:0]         mx, my, cl_m, cr_m;

	assign wa = wr_q[cmd_q.reg_a];
	assign wb = wr_q[cmd_q.reg_b];
	assign ea = ADDR_BITS'(cmd_q.address) +
		((cmd_q.reg_b != '0) ? ADDR_BITS'($signed(rdb_q)) : '0);
	assign mx = mag(rda_q);
	assign my = mag(opy_q);
	assign cl_m = mag(cmp_l_q);
	assign cr_m = mag(cmp_r_q);
	assign trial = {acc_q, sh_q[W-1]};
	assign out_free = !result_valid || result_ready;
	assign pop = (state_q == S_IDLE) && q_not_empty;
	assign bstat.clearing = state_q == S_CLEAR;

	always_comb begin
		unique case (cmd_q.opcode)
			rmme_pkg::OP_JMP:   take = 1'b1;
			rmme_pkg::OP_JEQ:   take = cmp_l_q == cmp_r_q;
			rmme_pkg::OP_JNE:   take = cmp_l_q != cmp_r_q;
			rmme_pkg::OP_JLT:   take = $signed(cmp_l_q) < $signed(cmp_r_q);
			rmme_pkg::OP_JGE:   take = $signed(cmp_l_q) >= $signed(cmp_r_q);
			rmme_pkg::OP_JGT:   take = $signed(cmp_l_q) > $signed(cmp_r_q);
			rmme_pkg::OP_JLE:   take = $signed(cmp_l_q) <= $signed(cmp_r_q);
			rmme_pkg::OP_JLT_A: take = cl_m < cr_m;
			rmme_pkg::OP_JGE_A: take = cl_m >= cr_m;
			rmme_pkg::OP_JGT_A: take = cl_m > cr_m;
			rmme_pkg::OP_JLE_A: take = cl_m <= cr_m;
			default:            take = 1'b0;
		endcase
	end

	// register file and memory write/read ports
	always_comb begin
		rf_we  = 1'b0;
		rf_wa  = cmd_q.reg_a;
		rf_wd  = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = ea;
		mem_wd = {1'b1, rda_q};
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_REG: begin
				unique case (cmd_q.cls)
					rmme_pkg::CL_INIT: begin
						mem_we = 1'b1;
						mem_wa = ADDR_BITS'(cmd_q.address);
						mem_wd = {1'b1, W'(cmd_q.init_value & IV_MASK)};
					end
					rmme_pkg::CL_RR: begin
						if (cmd_q.kind == rmme_pkg::K_MOV) begin
							rf_we = wb;
							rf_wd = rdb_q;
						end else if (cmd_q.kind == rmme_pkg::K_SUB &&
							cmd_q.reg_a == cmd_q.reg_b) begin
							rf_we = 1'b1;
						end
					end
					rmme_pkg::CL_RM: begin
						if ((cmd_q.kind == rmme_pkg::K_LOAD || wa) &&
							(cmd_q.reg_b == '0 || wb)) begin
							mem_we = cmd_q.kind == rmme_pkg::K_STORE;
							mem_re = cmd_q.kind != rmme_pkg::K_STORE;
						end
					end
					default: ;
				endcase
			end
			S_MEM: begin
				rf_we = mem_rd_q[W] && cmd_q.kind == rmme_pkg::K_LOAD;
				rf_wd = mem_rd_q[W-1:0];
			end
			S_EXEC: begin
				rf_we = cmd_q.kind == rmme_pkg::K_ADD || cmd_q.kind == rmme_pkg::K_SUB;
				rf_wd = (cmd_q.kind == rmme_pkg::K_ADD) ? rda_q + opy_q : rda_q - opy_q;
			end
			S_FIX: begin
				rf_we = 1'b1;
				if (cmd_q.kind == rmme_pkg::K_MUL || cmd_q.kind == rmme_pkg::K_AMUL) begin
					rf_wd = acc_q;
				end else begin
					rf_wd = (cmd_q.kind == rmme_pkg::K_DIV &&
						(rda_q[W-1] ^ opy_q[W-1])) ? ~sh_q + 1'b1 : sh_q;
				end
			end
			S_WR2: begin
				rf_we = 1'b1;
				rf_wa = cmd_q.reg_a + 4'd1;
				// for a signed divide the remainder takes the original dividend's sign
				rf_wd = (cmd_q.kind == rmme_pkg::K_DIV && rda_q[W-1]) ?
					~acc_q + 1'b1 : acc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		if (pop) begin
			rda_q <= rf[head.reg_a];
			rdb_q <= rf[head.reg_b];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[ea];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			wr_q         <= '0;
			cmp_l_q      <= '0;
			cmp_r_q      <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (rf_we) wr_q[rf_wa] <= 1'b1;
			if (state_q == S_DONE && out_free) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (q_not_empty) state_q <= S_REG;
				S_REG: begin
					if (cmd_q.cls == rmme_pkg::CL_RR && cmd_q.kind != rmme_pkg::K_MOV &&
						!(cmd_q.kind == rmme_pkg::K_SUB && cmd_q.reg_a == cmd_q.reg_b) &&
						wa && wb) begin
						state_q <= S_EXEC;
					end else if (mem_re) begin
						state_q <= S_MEM;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MEM: begin
					state_q <= (mem_rd_q[W] && cmd_q.kind != rmme_pkg::K_LOAD) ?
						S_EXEC : S_DONE;
				end
				S_EXEC: begin
					cnt_q <= CW'(W - 1);
					unique case (cmd_q.kind)
						rmme_pkg::K_CMP: begin
							cmp_l_q <= rda_q;
							cmp_r_q <= opy_q;
							state_q <= S_DONE;
						end
						rmme_pkg::K_MUL, rmme_pkg::K_AMUL: state_q <= S_ITER;
						rmme_pkg::K_DIV, rmme_pkg::K_ADIV:
							state_q <= (opy_q == '0) ? S_DONE : S_ITER;
						default: state_q <= S_DONE;
					endcase
				end
				S_ITER: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_FIX;
				end
				S_FIX: begin
					state_q <= (cmd_q.kind == rmme_pkg::K_DIV ||
						cmd_q.kind == rmme_pkg::K_ADIV) ? S_WR2 : S_DONE;
				end
				S_WR2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					cmd_q    <= head;
					res_st_q <= rmme_pkg::ST_OK;
					res_tk_q <= 1'b0;
					res_hl_q <= 1'b0;
					res_tg_q <= '0;
				end
			end
			S_REG: begin
				opy_q <= rdb_q;
				unique case (cmd_q.cls)
					rmme_pkg::CL_HALT: res_hl_q <= 1'b1;
					rmme_pkg::CL_RR: begin
						if (cmd_q.kind == rmme_pkg::K_MOV) begin
							if (!wb) res_st_q <= rmme_pkg::ST_NOREG;
						end else if (!(cmd_q.kind == rmme_pkg::K_SUB &&
							cmd_q.reg_a == cmd_q.reg_b) && !(wa && wb)) begin
							res_st_q <= rmme_pkg::ST_NOREG;
						end
					end
					rmme_pkg::CL_RM: begin
						if (!(cmd_q.kind == rmme_pkg::K_LOAD || wa) ||
							!(cmd_q.reg_b == '0 || wb)) begin
							res_st_q <= rmme_pkg::ST_NOREG;
						end
					end
					rmme_pkg::CL_JUMP: begin
						if (cmd_q.reg_b != '0 && !wb) begin
							res_st_q <= rmme_pkg::ST_NOREG;
						end else begin
							res_tg_q <= 16'(ea);
							res_tk_q <= take;
						end
					end
					default: ;
				endcase
			end
			S_MEM: begin
				opy_q <= mem_rd_q[W-1:0];
				if (!mem_rd_q[W]) res_st_q <= rmme_pkg::ST_NOMEM;
			end
			S_EXEC: begin
				acc_q <= '0;
				unique case (cmd_q.kind)
					rmme_pkg::K_MUL: begin
						opx_q <= rda_q;
						sh_q  <= opy_q;
					end
					rmme_pkg::K_AMUL: begin
						opx_q <= mx;
						sh_q  <= my;
					end
					rmme_pkg::K_DIV, rmme_pkg::K_ADIV: begin
						opx_q <= my;
						sh_q  <= mx;
						if (opy_q == '0) res_st_q <= rmme_pkg::ST_DIVZ;
					end
					default: ;
				endcase
			end
			S_ITER: begin
				if (cmd_q.kind == rmme_pkg::K_MUL || cmd_q.kind == rmme_pkg::K_AMUL) begin
					sh_q  <= sh_q << 1;
					acc_q <= (acc_q << 1) + (sh_q[W-1] ? opx_q : '0);
				end else if (trial >= {1'b0, opx_q}) begin
					acc_q <= W'(trial - {1'b0, opx_q});
					sh_q  <= {sh_q[W-2:0], 1'b1};
				end else begin
					acc_q <= trial[W-1:0];
					sh_q  <= {sh_q[W-2:0], 1'b0};
				end
			end
			S_DONE: begin
				if (out_free) begin
					status       <= res_st_q;
					branch_taken <= res_tk_q;
					jump_target  <= res_tg_q;
					halt         <= res_hl_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/rmme_checker.sv]
// ----------------------------------------------------------------------------
// rmme_checker
// Port-level checks for the execute block, bound to the top level.
// ----------------------------------------------------------------------------
module rmme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic        branch_taken,
	input logic [15:0] jump_target,
	input logic        halt
);

	// hold a stalled request
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid)
		else $error("request dropped while stalled");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) &&
		$stable(jump_target) && $stable(branch_taken) && $stable(halt))
		else $error("result changed while stalled");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && halt |-> status == rmme_pkg::ST_OK && !branch_taken &&
		jump_target == 16'd0)
		else $error("stop result carries other fields");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != rmme_pkg::ST_OK |-> !branch_taken &&
		jump_target == 16'd0 && !halt)
		else $error("error result carries a jump or stop");

	a_rst: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result shown out of reset");

endmodule

bind register_memory_machine_execute rmme_checker u_rmme_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.status       (status),
	.branch_taken (branch_taken),
	.jump_target  (jump_target),
	.halt         (halt)
);
